// File: design/smvm_pkg.sv
// Shared types and constants of the sparse matrix-vector multiply unit.
package smvm_pkg;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned ROW_W = 16;
  localparam int unsigned LEN_W = 11;
  localparam int unsigned TAG_W = 8;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned VEC_LEN_DEFAULT = 1024;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NONZERO = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_NONZERO,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [INDEX_W-1:0] index;
    logic               in_range;
    logic [VALUE_W-1:0] value;
    logic [ROW_W-1:0]   row;
    logic               row_end;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// File: design/smvm_in_if.sv
// Input channel interface carrying load, nonzero and clear transactions.
interface smvm_in_if;
  logic                                valid;
  logic                                ready;
  logic [smvm_pkg::KIND_W-1:0]         kind;
  logic [smvm_pkg::INDEX_W-1:0]        index;
  logic signed [smvm_pkg::VALUE_W-1:0] value;
  logic [smvm_pkg::ROW_W-1:0]          row_number;
  logic                                row_end;

  modport source (output valid, kind, index, value, row_number, row_end, input ready);
  modport sink (input valid, kind, index, value, row_number, row_end, output ready);
endinterface

// File: design/smvm_out_if.sv
// Result channel interface carrying one row result per transaction.
interface smvm_out_if;
  logic                                valid;
  logic                                ready;
  logic [smvm_pkg::ROW_W-1:0]          out_row;
  logic signed [smvm_pkg::VALUE_W-1:0] row_sum;
  logic                                row_hit;

  modport source (output valid, out_row, row_sum, row_hit, input ready);
  modport sink (input valid, out_row, row_sum, row_hit, output ready);
endinterface

// File: design/sparse_matrix_vector_multiply_unit.sv
// Top level of the sparse matrix times sparse vector unit.
// The unit accepts one transaction per cycle while its queue is not full; each classified item
// passes through the back-end pipeline, whose vector and presence stores each have one
// write and one read port. The transaction that ends a row passes through the queue, the b1 and b2
// registers and the result register before its row result is valid; a stalled output holds the pipeline.
// Presence is kept as an epoch tag per vector entry, so a clear normally only advances the
// epoch; after reset, and on every 255th clear, the tag store is swept entry by entry instead, during
// which the four-entry queue fills and input then stalls. Configuration writes are taken at any time.
module sparse_matrix_vector_multiply_unit #(
  parameter int unsigned VEC_LEN = smvm_pkg::VEC_LEN_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  smvm_in_if.sink                    in_ch,
  smvm_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [smvm_pkg::LEN_W-1:0] cfg_wdata
);
  import smvm_pkg::*;

  q_push_t   q_push;
  q_status_t q_status;
  q_entry_t  head;
  logic      pop;

  smvm_front #(.VEC_LEN(VEC_LEN)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_status  (q_status),
    .q_push    (q_push)
  );

  smvm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_push   (q_push),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  smvm_back #(.VEC_LEN(VEC_LEN)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// File: design/smvm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module smvm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/smvm_front.sv
// Front end: accepts input transactions, holds the length register and classifies items.
module smvm_front #(
  parameter int unsigned VEC_LEN = smvm_pkg::VEC_LEN_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  smvm_in_if.sink                    in_ch,
  input  logic                       cfg_we,
  input  logic [smvm_pkg::LEN_W-1:0] cfg_wdata,
  input  smvm_pkg::q_status_t        q_status,
  output smvm_pkg::q_push_t          q_push
);
  import smvm_pkg::*;

  logic [LEN_W-1:0] active_length_r;
  logic             accept;
  logic             in_store;
  logic             below_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_length_r <= LEN_RESET;
    end else if (cfg_we) begin
      active_length_r <= cfg_wdata;
    end
  end

  assign in_ch.ready = !q_status.full;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_store = 32'(in_ch.index) < 32'(VEC_LEN);
  assign below_len = LEN_W'(in_ch.index) < active_length_r;

  always_comb begin
    q_push.push = 1'b0;
    q_push.entry.op = OP_NONZERO;
    q_push.entry.index = in_ch.index;
    q_push.entry.in_range = in_store && below_len;
    q_push.entry.value = in_ch.value;
    q_push.entry.row = in_ch.row_number;
    q_push.entry.row_end = in_ch.row_end;
    unique case (in_ch.kind)
      KIND_LOAD: begin
        q_push.entry.op = OP_LOAD;
        q_push.push = accept && in_store;
      end
      KIND_NONZERO: begin
        q_push.entry.op = OP_NONZERO;
        q_push.push = accept;
      end
      KIND_CLEAR: begin
        q_push.entry.op = OP_CLEAR;
        q_push.push = accept;
      end
      default: begin
        q_push.push = 1'b0;
      end
    endcase
  end

`ifndef SYNTH
  a_unused_kind_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.kind == KIND_UNUSED) |-> !q_push.push)
    else $error("unused kind was queued");
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.full |-> !q_push.push)
    else $error("push while queue full");
`endif

endmodule

// File: design/smvm_queue.sv
// Short queue of classified items between the front and back ends.
module smvm_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  smvm_pkg::q_push_t   q_push,
  input  logic                pop,
  output smvm_pkg::q_entry_t  head,
  output smvm_pkg::q_status_t q_status
);
  import smvm_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  q_entry_t         entries_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (q_push.push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_push.push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !q_push.push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      entries_r[wr_ptr_r] <= q_push.entry;
    end
  end

  assign head = entries_r[rd_ptr_r];
  assign q_status.empty = (count_r == '0);
  assign q_status.full = (count_r == CNT_W'(QUEUE_DEPTH));

`ifndef SYNTH
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> !pop)
    else $error("pop from empty queue");
`endif

endmodule

// File: design/smvm_back.sv
// Back end: vector and presence stores, multiply, accumulate and result register.
module smvm_back #(
  parameter int unsigned VEC_LEN = smvm_pkg::VEC_LEN_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  smvm_pkg::q_entry_t  head,
  input  smvm_pkg::q_status_t q_status,
  output logic                pop,
  smvm_out_if.source          out_ch
);
  import smvm_pkg::*;

  localparam int unsigned AW = $clog2(VEC_LEN);
  localparam logic [AW-1:0] ADDR_LAST = AW'(VEC_LEN - 1);
  localparam logic [TAG_W-1:0] EPOCH_FIRST = TAG_W'(1);
  localparam logic [TAG_W-1:0] EPOCH_LAST = '1;

  typedef enum logic {
    ST_SWEEP,
    ST_RUN
  } state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      sweep_cnt_r, sweep_cnt_nxt;
  logic [TAG_W-1:0]   epoch_r, epoch_nxt;
  logic               b1_valid_r, b1_valid_nxt;
  logic               b2_valid_r;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic               hit_r, hit_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               b1_in_range_r;
  logic [TAG_W-1:0]   b1_epoch_r;
  logic [VALUE_W-1:0] b1_value_r;
  logic [ROW_W-1:0]   b1_row_r;
  logic               b1_row_end_r;
  logic [VALUE_W-1:0] b2_prod_r;
  logic               b2_hit_r;
  logic [ROW_W-1:0]   b2_row_r;
  logic               b2_row_end_r;
  logic [ROW_W-1:0]   out_row_r;
  logic [VALUE_W-1:0] out_sum_r;
  logic               out_hit_r;

  logic                  adv;
  logic [AW+INDEX_W-1:0] index_ext;
  logic [AW-1:0]         addr;
  logic                  vec_we;
  logic                  tag_we;
  logic [AW-1:0]         tag_waddr;
  logic [TAG_W-1:0]      tag_wdata;
  logic [VALUE_W-1:0]    vec_rdata;
  logic [TAG_W-1:0]      tag_rdata;
  logic                  present;
  logic [VALUE_W-1:0]    prod;
  logic [VALUE_W-1:0]    sum;

  assign index_ext = {{AW{1'b0}}, head.index};
  assign addr = index_ext[AW-1:0];
  assign adv = !out_valid_r || out_ch.ready;

  smvm_ram #(.WIDTH(VALUE_W), .DEPTH(VEC_LEN)) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (addr),
    .wdata (head.value),
    .re    (adv),
    .raddr (addr),
    .rdata (vec_rdata)
  );

  smvm_ram #(.WIDTH(TAG_W), .DEPTH(VEC_LEN)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .re    (adv),
    .raddr (addr),
    .rdata (tag_rdata)
  );

  assign present = b1_in_range_r && (tag_rdata == b1_epoch_r);
  assign prod = present ? VALUE_W'(b1_value_r * vec_rdata) : '0;
  assign sum = acc_r + b2_prod_r;

  always_comb begin
    state_nxt = state_r;
    sweep_cnt_nxt = sweep_cnt_r;
    epoch_nxt = epoch_r;
    pop = 1'b0;
    vec_we = 1'b0;
    tag_we = 1'b0;
    tag_waddr = addr;
    tag_wdata = epoch_r;
    b1_valid_nxt = b1_valid_r;
    unique case (state_r)
      ST_SWEEP: begin
        tag_we = 1'b1;
        tag_waddr = sweep_cnt_r;
        tag_wdata = '0;
        if (sweep_cnt_r == ADDR_LAST) begin
          state_nxt = ST_RUN;
          epoch_nxt = EPOCH_FIRST;
        end else begin
          sweep_cnt_nxt = sweep_cnt_r + 1'b1;
        end
        if (adv) begin
          b1_valid_nxt = 1'b0;
        end
      end
      ST_RUN: begin
        pop = adv && !q_status.empty;
        if (adv) begin
          b1_valid_nxt = pop && (head.op == OP_NONZERO);
        end
        if (pop) begin
          unique case (head.op)
            OP_LOAD: begin
              vec_we = 1'b1;
              tag_we = 1'b1;
            end
            OP_CLEAR: begin
              if (epoch_r == EPOCH_LAST) begin
                state_nxt = ST_SWEEP;
                sweep_cnt_nxt = '0;
              end else begin
                epoch_nxt = epoch_r + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_SWEEP;
      end
    endcase
  end

  always_comb begin
    acc_nxt = acc_r;
    hit_nxt = hit_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = b2_valid_r && b2_row_end_r;
      if (b2_valid_r) begin
        if (b2_row_end_r) begin
          acc_nxt = '0;
          hit_nxt = 1'b0;
        end else begin
          acc_nxt = sum;
          hit_nxt = hit_r || b2_hit_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
      sweep_cnt_r <= '0;
      epoch_r <= '0;
      b1_valid_r <= 1'b0;
      b2_valid_r <= 1'b0;
      acc_r <= '0;
      hit_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      epoch_r <= epoch_nxt;
      b1_valid_r <= b1_valid_nxt;
      if (adv) begin
        b2_valid_r <= b1_valid_r;
      end
      acc_r <= acc_nxt;
      hit_r <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (adv) begin
      b1_in_range_r <= head.in_range;
      b1_epoch_r <= epoch_r;
      b1_value_r <= head.value;
      b1_row_r <= head.row;
      b1_row_end_r <= head.row_end;
      b2_prod_r <= prod;
      b2_hit_r <= present;
      b2_row_r <= b1_row_r;
      b2_row_end_r <= b1_row_end_r;
      out_row_r <= b2_row_r;
      out_sum_r <= sum;
      out_hit_r <= hit_r || b2_hit_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_row = out_row_r;
  assign out_ch.row_sum = out_sum_r;
  assign out_ch.row_hit = out_hit_r;

`ifndef SYNTH
  a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> !pop)
    else $error("queue popped during presence sweep");
  a_epoch_nonzero_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (epoch_r != '0))
    else $error("zero epoch while running");
  a_row_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && b2_valid_r && b2_row_end_r) |=> out_valid_r)
    else $error("row end did not produce a result");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the sparse matrix-vector multiply unit.
`timescale 1ns / 100ps

module tb_top;
  import smvm_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = VEC_LEN_DEFAULT + 50;
  localparam int unsigned LONG_HOLD = 400;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
    logic [ROW_W-1:0]   row;
    logic               last;
  } tx_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [VALUE_W-1:0] sum;
    logic               hit;
  } row_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [LEN_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  tx_item_t drive_item = '0;
  logic rx_ready = 1'b0;

  smvm_in_if in_bus ();
  smvm_out_if out_bus ();

  assign in_bus.valid = in_valid;
  assign in_bus.kind = drive_item.kind;
  assign in_bus.index = drive_item.index;
  assign in_bus.value = drive_item.value;
  assign in_bus.row_number = drive_item.row;
  assign in_bus.row_end = drive_item.last;
  assign out_bus.ready = rx_ready;

  sparse_matrix_vector_multiply_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  tx_item_t item_q[$];
  row_result_t expected_rows[$];
  int unsigned loaded_cols[$];

  logic [VALUE_W-1:0] vec_store [VEC_LEN_DEFAULT];
  logic [VEC_LEN_DEFAULT-1:0] vec_present = '0;
  logic [VALUE_W-1:0] row_acc = '0;
  logic row_hit_mark = 1'b0;
  logic [LEN_W-1:0] active_len = LEN_RESET;

  int unsigned items_accepted = 0;
  int unsigned rows_checked = 0;
  int unsigned rows_hit = 0;
  int unsigned mismatches = 0;
  int unsigned settings_run = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;
  int unsigned rx_mode = 0;
  int unsigned mode_left = 0;
  int unsigned rx_cycle = 0;
  int unsigned stall_cycles = 0;

  task automatic predict_item(input tx_item_t it);
    row_result_t res;
    case (it.kind)
      KIND_LOAD: begin
        vec_store[it.index] = it.value;
        vec_present[it.index] = 1'b1;
      end
      KIND_CLEAR: vec_present = '0;
      KIND_NONZERO: begin
        if (it.index < active_len && vec_present[it.index]) begin
          row_acc = row_acc + it.value * vec_store[it.index];
          row_hit_mark = 1'b1;
        end
        if (it.last) begin
          res.row = it.row;
          res.sum = row_acc;
          res.hit = row_hit_mark;
          expected_rows.push_back(res);
          row_acc = '0;
          row_hit_mark = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  // The sender offers items in bursts separated by random gaps.
  always @(posedge clk) begin
    logic offering;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offering = in_valid;
      if (in_valid && in_bus.ready) begin
        predict_item(drive_item);
        items_accepted++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (item_q.size() > 0) begin
          drive_item <= item_q.pop_front();
          offering = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(50, 150);
              gap_left = 0;
            end else begin
              burst_left = $urandom_range(1, 20);
              gap_left = $urandom_range(0, 6);
            end
          end
        end
      end
      in_valid <= offering;
    end
  end

  // The receiver switches between stall patterns and takes long holds on request.
  always @(posedge clk) begin
    logic rdy;
    if (!rst_n) begin
      rx_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_ack != hold_req) begin
        hold_ack = hold_req;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(64, 256);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (rx_mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          default: rdy = (rx_cycle % 4) != 3;
        endcase
      end
      rx_ready <= rdy;
    end
  end

  always @(posedge clk) begin
    row_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      rows_checked++;
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected row result: row %0d sum %0d hit %0d",
                   out_bus.out_row, out_bus.row_sum, out_bus.row_hit);
      end else begin
        want = expected_rows.pop_front();
        if (out_bus.row_hit) rows_hit++;
        if (out_bus.out_row !== want.row || out_bus.row_sum !== want.sum ||
            out_bus.row_hit !== want.hit) begin
          mismatches++;
          if (mismatches <= 10)
            $display("row mismatch: expected row %0d sum %0d hit %0d, got row %0d sum %0d hit %0d",
                     want.row, $signed(want.sum), want.hit,
                     out_bus.out_row, out_bus.row_sum, out_bus.row_hit);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (item_q.size() == 0 && !in_valid && expected_rows.size() == 0)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("watchdog: no transaction for %0d cycles", stall_cycles);
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  task automatic push(input logic [KIND_W-1:0] kind, input logic [INDEX_W-1:0] idx,
                      input logic [VALUE_W-1:0] val, input logic [ROW_W-1:0] row,
                      input logic last);
    tx_item_t it;
    it.kind = kind;
    it.index = idx;
    it.value = val;
    it.row = row;
    it.last = last;
    item_q.push_back(it);
    if (kind == KIND_LOAD) loaded_cols.push_back(32'(idx));
    if (kind == KIND_CLEAR) loaded_cols.delete();
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3, 4, 5: return $urandom_range(0, 40) - 20;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] pick_col(input int unsigned pool_hi);
    if ($urandom_range(0, 9) == 0) return INDEX_W'($urandom_range(0, VEC_LEN_DEFAULT - 1));
    return INDEX_W'($urandom_range(0, pool_hi - 1));
  endfunction

  function automatic logic [INDEX_W-1:0] row_col(input int unsigned pool_hi);
    if (loaded_cols.size() > 0 && $urandom_range(0, 3) != 0)
      return INDEX_W'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
    return pick_col(pool_hi);
  endfunction

  // Mostly well-formed rows over loaded columns, mixed with loads, clears and noise.
  task automatic random_items(input int unsigned count);
    int unsigned done;
    int unsigned pool_hi;
    int unsigned len;
    int unsigned r;
    logic [ROW_W-1:0] row;
    done = 0;
    pool_hi = (active_len == 0) ? 16 :
              ((active_len + 4 > VEC_LEN_DEFAULT) ? VEC_LEN_DEFAULT : active_len + 4);
    while (done < count) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        push(KIND_LOAD, pick_col(pool_hi), rand_value(), ROW_W'($urandom),
             1'($urandom_range(0, 1)));
        done++;
      end else if (r < 23) begin
        push(KIND_CLEAR, INDEX_W'($urandom), $urandom, ROW_W'($urandom),
             1'($urandom_range(0, 1)));
        done++;
      end else if (r < 25) begin
        push(KIND_UNUSED, INDEX_W'($urandom), $urandom, ROW_W'($urandom),
             1'($urandom_range(0, 1)));
      end else if (r < 28) begin
        push(KIND_NONZERO, INDEX_W'($urandom), rand_value(), ROW_W'($urandom),
             1'($urandom_range(0, 1)));
        done++;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
        row = ROW_W'($urandom);
        for (int unsigned k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            push(KIND_LOAD, pick_col(pool_hi), rand_value(), ROW_W'($urandom),
                 1'($urandom_range(0, 1)));
            done++;
          end
          push(KIND_NONZERO, row_col(pool_hi), rand_value(), row, k == len - 1);
          done++;
        end
      end
    end
  endtask

  task automatic set_active_length(input logic [LEN_W-1:0] len);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    active_len = len;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  task automatic wait_idle();
    while (item_q.size() != 0 || in_valid || expected_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned stale[$];
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    set_active_length(LEN_RESET);
    push(KIND_LOAD, 10'd0, 32'h7fff_ffff, 16'd0, 1'b0);
    push(KIND_LOAD, INDEX_W'(VEC_LEN_DEFAULT - 1), 32'h8000_0000, 16'd0, 1'b1);
    push(KIND_LOAD, 10'd512, 32'hffff_ffff, 16'hffff, 1'b0);
    push(KIND_LOAD, 10'd1, 32'd3, 16'd0, 1'b0);
    push(KIND_NONZERO, 10'd0, 32'h7fff_ffff, 16'd0, 1'b0);
    push(KIND_NONZERO, INDEX_W'(VEC_LEN_DEFAULT - 1), 32'hffff_ffff, 16'd0, 1'b1);
    push(KIND_NONZERO, 10'd5, 32'd12345, 16'd1, 1'b1);
    push(KIND_NONZERO, 10'd512, 32'h8000_0000, 16'hffff, 1'b0);
    push(KIND_LOAD, 10'd2, 32'd10, 16'hffff, 1'b1);
    push(KIND_UNUSED, 10'd2, 32'hffff_ffff, 16'hffff, 1'b1);
    push(KIND_NONZERO, 10'd2, 32'd5, 16'hffff, 1'b1);
    push(KIND_NONZERO, 10'd1, 32'd0, 16'd2, 1'b1);
    push(KIND_CLEAR, 10'd0, 32'd0, 16'd0, 1'b0);
    push(KIND_NONZERO, 10'd0, 32'd1, 16'd3, 1'b1);
    push(KIND_LOAD, INDEX_W'(VEC_LEN_DEFAULT - 1), 32'd7, 16'd0, 1'b0);
    push(KIND_NONZERO, INDEX_W'(VEC_LEN_DEFAULT - 1), 32'd2, 16'd4, 1'b1);
    push(KIND_LOAD, 10'd3, 32'h7fff_ffff, 16'd0, 1'b0);
    push(KIND_NONZERO, 10'd3, 32'h7fff_ffff, 16'd5, 1'b0);
    push(KIND_NONZERO, 10'd3, 32'h7fff_ffff, 16'd5, 1'b1);
    push(KIND_UNUSED, INDEX_W'(VEC_LEN_DEFAULT - 1), 32'hffff_ffff, 16'hffff, 1'b1);
    wait_idle();

    set_active_length(LEN_RESET);
    random_items(140);
    hold_req++;
    wait_idle();

    set_active_length(11'd1);
    random_items(60);
    wait_idle();

    set_active_length(11'd0);
    random_items(50);
    wait_idle();

    set_active_length(11'd2047);
    random_items(100);
    wait_idle();

    // Enough clears in a row to wrap the presence epoch.
    set_active_length(LEN_W'($urandom_range(2, VEC_LEN_DEFAULT - 1)));
    random_items(40);
    for (int unsigned k = 0; k < VEC_LEN_DEFAULT; k++)
      if (vec_present[k] && k < active_len) stale.push_back(k);
    repeat (256) push(KIND_CLEAR, INDEX_W'($urandom), $urandom, ROW_W'($urandom),
                      1'($urandom_range(0, 1)));
    foreach (stale[k])
      if (k < 8) push(KIND_NONZERO, INDEX_W'(stale[k]), rand_value(), ROW_W'($urandom), 1'b1);
    random_items(100);
    wait_idle();

    set_active_length(11'd16);
    random_items(70);
    wait_idle();

    set_active_length(11'd1500);
    random_items(90);
    wait_idle();

    if (expected_rows.size() != 0) begin
      mismatches += expected_rows.size();
      $display("%0d expected row results never arrived", expected_rows.size());
    end
    $display("summary: %0d input transactions over %0d length settings, %0d row results (%0d hit)",
             items_accepted, settings_run, rows_checked, rows_hit);
    $display("summary: %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
